// File: design/vpma_pkg.sv
`default_nettype none
package vpma_pkg;

  localparam int unsigned PLANES = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = PLANES * BYTE_W;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SET_RESET        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_SET_RESET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_AND_CARE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_AND_OP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READ_PLANE_SEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_SELECT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MASK         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_WR_EN      = 3'd7;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] WMODE_0 = 2'd0;
  localparam logic [1:0] WMODE_1 = 2'd1;
  localparam logic [1:0] WMODE_2 = 2'd2;
  localparam logic [1:0] WMODE_3 = 2'd3;

  localparam logic [1:0] ROP_NONE = 2'd0;
  localparam logic [1:0] ROP_AND  = 2'd1;
  localparam logic [1:0] ROP_OR   = 2'd2;
  localparam logic [1:0] ROP_XOR  = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [3:0] set_reset;
    logic [3:0] enable_set_reset;
    logic [7:0] compare_and_care;
    logic [4:0] rotate_and_op;
    logic [1:0] read_plane_sel;
    logic [2:0] mode_select;
    logic [7:0] bit_mask;
    logic [3:0] plane_wr_en;
  } cfg_t;

  function automatic word_t spread_byte(input logic [BYTE_W-1:0] b);
    return {PLANES{b}};
  endfunction

  function automatic word_t plane_fill(input logic [PLANES-1:0] n);
    word_t r;
    for (int p = 0; p < PLANES; p++) begin
      r[p*BYTE_W +: BYTE_W] = {BYTE_W{n[p]}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/vpma_in_if.sv
`default_nettype none
interface vpma_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input address, input write_data,
                output ready);
endinterface
`default_nettype wire

// File: design/vpma_out_if.sv
`default_nettype none
interface vpma_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface
`default_nettype wire

// File: design/vpma_plane_mem.sv
`default_nettype none
module vpma_plane_mem #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic                           wr_en,
  input  wire logic [vpma_pkg::PLANES-1:0]    wr_be,
  input  wire logic [ADDR_W-1:0]              addr,
  input  wire vpma_pkg::word_t                wr_data,
  output vpma_pkg::word_t                     rd_data_r
);

  vpma_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int p = 0; p < vpma_pkg::PLANES; p++) begin
        if (wr_be[p]) begin
          mem[addr][p*vpma_pkg::BYTE_W +: vpma_pkg::BYTE_W] <=
            wr_data[p*vpma_pkg::BYTE_W +: vpma_pkg::BYTE_W];
        end
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: design/vpma_write_unit.sv
`default_nettype none
module vpma_write_unit (
  input  wire vpma_pkg::cfg_t  cfg,
  input  wire vpma_pkg::word_t latch,
  input  wire logic [7:0]      host,
  output vpma_pkg::word_t      data
);

  logic [2:0]      rot_cnt;
  logic [15:0]     host_dbl;
  logic [7:0]      host_rot;
  vpma_pkg::word_t full_mask;
  vpma_pkg::word_t d0;
  vpma_pkg::word_t lu_data;
  vpma_pkg::word_t lu_sel;
  vpma_pkg::word_t lu_out;

  assign rot_cnt   = cfg.rotate_and_op[2:0];
  assign host_dbl  = {host, host} >> rot_cnt;
  assign host_rot  = host_dbl[7:0];
  assign full_mask = vpma_pkg::spread_byte(cfg.bit_mask);
  assign d0 = (vpma_pkg::spread_byte(host_rot) & ~vpma_pkg::plane_fill(cfg.enable_set_reset))
            | vpma_pkg::plane_fill(cfg.enable_set_reset & cfg.set_reset);

  always_comb begin
    case (cfg.mode_select[1:0])
      vpma_pkg::WMODE_0: begin
        lu_data = d0;
        lu_sel  = full_mask;
      end
      vpma_pkg::WMODE_2: begin
        lu_data = vpma_pkg::plane_fill(host[3:0]);
        lu_sel  = full_mask;
      end
      default: begin
        lu_data = vpma_pkg::plane_fill(cfg.set_reset);
        lu_sel  = vpma_pkg::spread_byte(host_rot) & full_mask;
      end
    endcase
  end

  always_comb begin
    case (cfg.rotate_and_op[4:3])
      vpma_pkg::ROP_NONE: lu_out = (lu_data & lu_sel) | (latch & ~lu_sel);
      vpma_pkg::ROP_AND:  lu_out = (lu_data | ~lu_sel) & latch;
      vpma_pkg::ROP_OR:   lu_out = (lu_data & lu_sel) | latch;
      default:            lu_out = (lu_data & lu_sel) ^ latch;
    endcase
  end

  assign data = (cfg.mode_select[1:0] == vpma_pkg::WMODE_1) ? latch : lu_out;

endmodule
`default_nettype wire

// File: design/vga_planar_memory_access_top.sv
`default_nettype none
// Planar VGA memory path: four 8-bit planes share one address and sit in one
// single-port memory with per-plane byte enables. A write transaction needs no
// read, since the planes are written directly under the plane write mask. A read
// transaction waits on the registered read data of the plane memory; in the READ
// state the latch is loaded and the result registered. One transaction is in
// progress at a time, and every transaction returns one result byte (zero for
// writes). Addresses wrap modulo PLANE_DEPTH when it is a power of two or at least
// 16384. Plane contents are undefined until written.
module vga_planar_memory_access_top #(
  parameter int unsigned PLANE_DEPTH = 65536
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  vpma_in_if.sink                                  in_bus,
  vpma_out_if.source                               out_bus,
  input  wire logic                                cfg_we,
  input  wire logic [vpma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [vpma_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned AW = $clog2(PLANE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic            state_r, state_nxt;
  vpma_pkg::cfg_t  cfg_r;
  vpma_pkg::word_t latch_r, latch_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;

  logic            accept;
  logic            rd_en;
  logic            wr_en;
  logic [16:0]     addr_wrap;
  logic [AW-1:0]   mem_addr;
  vpma_pkg::word_t mem_rdata;
  vpma_pkg::word_t wr_data;
  vpma_pkg::word_t cmp_t;
  logic [7:0]      cmp_fold;
  logic [7:0]      rd_result;

  assign in_bus.ready = (state_r == ST_IDLE) && (!out_valid_r || out_bus.ready);
  assign accept       = in_bus.valid && in_bus.ready;
  assign rd_en        = accept && (in_bus.opcode == vpma_pkg::OP_READ);
  assign wr_en        = accept && (in_bus.opcode == vpma_pkg::OP_WRITE);

  always_comb begin
    addr_wrap = {1'b0, in_bus.address};
    for (int k = 0; k < 3; k++) begin
      if (addr_wrap >= 17'(PLANE_DEPTH)) begin
        addr_wrap = addr_wrap - 17'(PLANE_DEPTH);
      end
    end
  end
  assign mem_addr = addr_wrap[AW-1:0];

  vpma_plane_mem #(
    .DEPTH  (PLANE_DEPTH),
    .ADDR_W (AW)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .wr_en     (wr_en),
    .wr_be     (cfg_r.plane_wr_en),
    .addr      (mem_addr),
    .wr_data   (wr_data),
    .rd_data_r (mem_rdata)
  );

  vpma_write_unit u_write (
    .cfg   (cfg_r),
    .latch (latch_r),
    .host  (in_bus.write_data),
    .data  (wr_data)
  );

  assign cmp_t = (mem_rdata & vpma_pkg::plane_fill(cfg_r.compare_and_care[7:4]))
               ^ vpma_pkg::plane_fill(cfg_r.compare_and_care[3:0]
                                      & cfg_r.compare_and_care[7:4]);
  assign cmp_fold = cmp_t[7:0] | cmp_t[15:8] | cmp_t[23:16] | cmp_t[31:24];

  always_comb begin
    if (cfg_r.mode_select[2]) begin
      rd_result = ~cmp_fold;
    end else begin
      rd_result = mem_rdata[{cfg_r.read_plane_sel, 3'b000} +: 8];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    latch_nxt     = latch_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (rd_en) begin
          state_nxt = ST_READ;
        end else if (wr_en) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'h00;
        end
      end
      ST_READ: begin
        latch_nxt     = mem_rdata;
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_result;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      latch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      latch_r     <= latch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_reset        <= 4'h0;
      cfg_r.enable_set_reset <= 4'h0;
      cfg_r.compare_and_care <= 8'h00;
      cfg_r.rotate_and_op    <= 5'h00;
      cfg_r.read_plane_sel   <= 2'd0;
      cfg_r.mode_select      <= 3'd0;
      cfg_r.bit_mask         <= 8'hFF;
      cfg_r.plane_wr_en      <= 4'hF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vpma_pkg::REG_SET_RESET:        cfg_r.set_reset        <= cfg_data[3:0];
        vpma_pkg::REG_ENABLE_SET_RESET: cfg_r.enable_set_reset <= cfg_data[3:0];
        vpma_pkg::REG_COMPARE_AND_CARE: cfg_r.compare_and_care <= cfg_data;
        vpma_pkg::REG_ROTATE_AND_OP:    cfg_r.rotate_and_op    <= cfg_data[4:0];
        vpma_pkg::REG_READ_PLANE_SEL:   cfg_r.read_plane_sel   <= cfg_data[1:0];
        vpma_pkg::REG_MODE_SELECT:      cfg_r.mode_select      <= cfg_data[2:0];
        vpma_pkg::REG_BIT_MASK:         cfg_r.bit_mask         <= cfg_data;
        vpma_pkg::REG_PLANE_WR_EN:      cfg_r.plane_wr_en      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_data = out_data_r;

endmodule
`default_nettype wire

// File: tb/vpma_checker.sv
module vpma_checker #(
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  vpma_in_if                                   in_bus,
  vpma_out_if                                  out_bus,
  input  wire logic                            cfg_we,
  input  wire logic [vpma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vpma_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   outstanding
);

  vpma_pkg::word_t plane_mem [DEPTH];
  vpma_pkg::word_t read_latch;
  vpma_pkg::cfg_t  regs;
  logic [7:0]      pending_read_data [$];

  function automatic vpma_pkg::word_t fan_out(input logic [7:0] b);
    return {4{b}};
  endfunction

  function automatic vpma_pkg::word_t plane_bits(input logic [3:0] n);
    vpma_pkg::word_t w;
    for (int p = 0; p < 4; p++) begin
      w[8*p +: 8] = {8{n[p]}};
    end
    return w;
  endfunction

  function automatic logic [7:0] rotate_host(input logic [7:0] b, input logic [2:0] cnt);
    logic [15:0] twice;
    twice = {b, b} >> cnt;
    return twice[7:0];
  endfunction

  function automatic vpma_pkg::word_t raster(input vpma_pkg::word_t data,
                                             input vpma_pkg::word_t sel);
    case (regs.rotate_and_op[4:3])
      vpma_pkg::ROP_NONE: return (data & sel) | (read_latch & ~sel);
      vpma_pkg::ROP_AND:  return (data | ~sel) & read_latch;
      vpma_pkg::ROP_OR:   return (data & sel) | read_latch;
      default:            return (data & sel) ^ read_latch;
    endcase
  endfunction

  function automatic vpma_pkg::word_t compute_plane_write(input logic [7:0] host);
    vpma_pkg::word_t mask_w;
    vpma_pkg::word_t d;
    mask_w = fan_out(regs.bit_mask);
    case (regs.mode_select[1:0])
      vpma_pkg::WMODE_0: begin
        d = fan_out(rotate_host(host, regs.rotate_and_op[2:0]));
        d = (d & ~plane_bits(regs.enable_set_reset))
            | plane_bits(regs.enable_set_reset & regs.set_reset);
        return raster(d, mask_w);
      end
      vpma_pkg::WMODE_1: return read_latch;
      vpma_pkg::WMODE_2: return raster(plane_bits(host[3:0]), mask_w);
      default: return raster(plane_bits(regs.set_reset),
                             fan_out(rotate_host(host, regs.rotate_and_op[2:0])) & mask_w);
    endcase
  endfunction

  function automatic logic [7:0] read_result_byte();
    logic [3:0]      care;
    vpma_pkg::word_t t;
    care = regs.compare_and_care[7:4];
    if (!regs.mode_select[2]) begin
      return read_latch[8*regs.read_plane_sel +: 8];
    end
    t = (read_latch & plane_bits(care)) ^ plane_bits(regs.compare_and_care[3:0] & care);
    return ~(t[7:0] | t[15:8] | t[23:16] | t[31:24]);
  endfunction

  always @(posedge clk) begin
    int unsigned     slot;
    vpma_pkg::word_t fresh_word;
    vpma_pkg::word_t enables;
    logic [7:0]      want;
    if (!rst_n) begin
      regs = '0;
      regs.bit_mask = 8'hFF;
      regs.plane_wr_en = 4'hF;
      read_latch = '0;
      pending_read_data.delete();
      fail_count = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        slot = in_bus.address % DEPTH;
        if (in_bus.opcode == vpma_pkg::OP_READ) begin
          read_latch = plane_mem[slot];
          pending_read_data.push_back(read_result_byte());
        end else begin
          fresh_word = compute_plane_write(in_bus.write_data);
          enables = plane_bits(regs.plane_wr_en);
          plane_mem[slot] = (plane_mem[slot] & ~enables) | (fresh_word & enables);
          pending_read_data.push_back(8'h00);
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_read_data.size() == 0) begin
          $display("%0t: read_data expected none, actual %02h", $time, out_bus.read_data);
          fail_count++;
        end else begin
          want = pending_read_data.pop_front();
          if (out_bus.read_data !== want) begin
            $display("%0t: read_data expected %02h, actual %02h", $time, want,
                     out_bus.read_data);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          vpma_pkg::REG_SET_RESET:        regs.set_reset        = cfg_data[3:0];
          vpma_pkg::REG_ENABLE_SET_RESET: regs.enable_set_reset = cfg_data[3:0];
          vpma_pkg::REG_COMPARE_AND_CARE: regs.compare_and_care = cfg_data[7:0];
          vpma_pkg::REG_ROTATE_AND_OP:    regs.rotate_and_op    = cfg_data[4:0];
          vpma_pkg::REG_READ_PLANE_SEL:   regs.read_plane_sel   = cfg_data[1:0];
          vpma_pkg::REG_MODE_SELECT:      regs.mode_select      = cfg_data[2:0];
          vpma_pkg::REG_BIT_MASK:         regs.bit_mask         = cfg_data[7:0];
          default:                        regs.plane_wr_en      = cfg_data[3:0];
        endcase
      end
    end
    outstanding = pending_read_data.size();
  end

endmodule

// File: tb/vga_planar_memory_access_top_tb.sv
module vga_planar_memory_access_top_tb;

  localparam int unsigned DEPTH = 65536;
  localparam int ITEM_TARGET = 1750;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [vpma_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vpma_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              fail_count;
  int                              outstanding;

  vpma_in_if  in_bus ();
  vpma_out_if out_bus ();

  logic [3:0]  cur_plane_wr_en;
  bit   [3:0]  filled [DEPTH];
  logic [15:0] full_addrs [$];
  logic [15:0] hot_addrs [64];
  int          items_sent;
  bit          hold_off_go;
  bit          hold_off_used;

  vga_planar_memory_access_top #(.PLANE_DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vpma_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic drive_item(input logic op, input logic [15:0] addr, input logic [7:0] data);
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.opcode <= op;
    in_bus.address <= addr;
    in_bus.write_data <= data;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
    if (op == vpma_pkg::OP_WRITE) begin
      if (filled[addr] != 4'hF && (filled[addr] | cur_plane_wr_en) == 4'hF) begin
        full_addrs.push_back(addr);
      end
      filled[addr] |= cur_plane_wr_en;
    end
  endtask

  task automatic pause(input int cycles);
    @(negedge clk);
    in_bus.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  task automatic write_reg(input logic [vpma_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == vpma_pkg::REG_PLANE_WR_EN) cur_plane_wr_en = val[3:0];
  endtask

  task automatic program_registers(input logic [7:0] sr, input logic [7:0] esr,
                                   input logic [7:0] cc, input logic [7:0] ro,
                                   input logic [7:0] rps, input logic [7:0] ms,
                                   input logic [7:0] bm, input logic [7:0] pwe);
    drain();
    write_reg(vpma_pkg::REG_SET_RESET, sr);
    write_reg(vpma_pkg::REG_ENABLE_SET_RESET, esr);
    write_reg(vpma_pkg::REG_COMPARE_AND_CARE, cc);
    write_reg(vpma_pkg::REG_ROTATE_AND_OP, ro);
    write_reg(vpma_pkg::REG_READ_PLANE_SEL, rps);
    write_reg(vpma_pkg::REG_MODE_SELECT, ms);
    write_reg(vpma_pkg::REG_BIT_MASK, bm);
    write_reg(vpma_pkg::REG_PLANE_WR_EN, pwe);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    int         flavor;
    logic [7:0] pwe;
    flavor = $urandom_range(0, 9);
    if (flavor == 0) begin
      program_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    end else if (flavor == 1) begin
      program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    end else begin
      pwe = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 2) != 0) pwe[3:0] = 4'hF;
      program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), pwe);
    end
  endtask

  task automatic random_item();
    logic [15:0] addr;
    if (full_addrs.size() != 0 && $urandom_range(0, 99) < 45) begin
      addr = full_addrs[$urandom_range(0, full_addrs.size() - 1)];
      drive_item(vpma_pkg::OP_READ, addr, 8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 99) < 85) addr = hot_addrs[$urandom_range(0, 63)];
      else addr = 16'($urandom_range(0, 16'hFFFF));
      drive_item(vpma_pkg::OP_WRITE, addr, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int count, input bit gappy);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && count > 0) begin
        random_item();
        burst--;
        count--;
      end
      if (gappy && $urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    int style;
    int span;
    int tick;
    out_bus.ready = 1'b0;
    hold_off_used = 1'b0;
    tick = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off_go && !hold_off_used) begin
        hold_off_used = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          out_bus.ready <= 1'b0;
        end
      end
      style = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      while (span > 0 && !(hold_off_go && !hold_off_used)) begin
        @(negedge clk);
        case (style)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
          2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= (tick % 3 == 0);
        endcase
        tick++;
        span--;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("vga_planar_memory_access_top_tb: FAIL");
    $finish;
  end

  initial begin
    int phase;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = vpma_pkg::OP_READ;
    in_bus.address = '0;
    in_bus.write_data = '0;
    cfg_we = 1'b0;
    cfg_index = vpma_pkg::REG_SET_RESET;
    cfg_data = '0;
    cur_plane_wr_en = 4'hF;
    items_sent = 0;
    hold_off_go = 1'b0;
    hot_addrs[0] = 16'h0000;
    hot_addrs[1] = 16'hFFFF;
    hot_addrs[2] = 16'h5A5A;
    hot_addrs[3] = 16'h8001;
    for (int i = 4; i < 64; i++) hot_addrs[i] = 16'($urandom_range(0, 16'hFFFF));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    drive_item(vpma_pkg::OP_WRITE, 16'h0000, 8'h00);
    drive_item(vpma_pkg::OP_WRITE, 16'hFFFF, 8'hFF);
    drive_item(vpma_pkg::OP_WRITE, 16'h5A5A, 8'h3C);
    drive_item(vpma_pkg::OP_WRITE, 16'h8001, 8'hA5);
    drive_item(vpma_pkg::OP_READ, 16'hFFFF, 8'h00);
    drive_item(vpma_pkg::OP_READ, 16'h0000, 8'hFF);
    drive_item(vpma_pkg::OP_READ, 16'h5A5A, 8'h00);

    program_registers(8'h0A, 8'h06, 8'h3A, {3'b000, vpma_pkg::ROP_XOR, 3'd3}, 8'h02,
                      {5'b00000, 1'b1, vpma_pkg::WMODE_0}, 8'hF0, 8'h0F);
    drive_item(vpma_pkg::OP_READ, 16'h8001, 8'h00);
    drive_item(vpma_pkg::OP_READ, 16'h5A5A, 8'h00);
    drive_item(vpma_pkg::OP_WRITE, 16'h0000, 8'h81);
    drive_item(vpma_pkg::OP_READ, 16'h0000, 8'h00);

    program_registers(8'h00, 8'h00, 8'h00, {3'b000, vpma_pkg::ROP_NONE, 3'd0}, 8'h01,
                      {5'b00000, 1'b0, vpma_pkg::WMODE_1}, 8'hFF, 8'h05);
    drive_item(vpma_pkg::OP_READ, 16'hFFFF, 8'h00);
    drive_item(vpma_pkg::OP_WRITE, 16'h0000, 8'h5C);
    drive_item(vpma_pkg::OP_READ, 16'h0000, 8'h00);

    program_registers(8'h00, 8'h00, 8'h00, {3'b000, vpma_pkg::ROP_AND, 3'd0}, 8'h03,
                      {5'b00000, 1'b0, vpma_pkg::WMODE_2}, 8'h0F, 8'h0F);
    drive_item(vpma_pkg::OP_WRITE, 16'h5A5A, 8'hF6);
    drive_item(vpma_pkg::OP_READ, 16'h5A5A, 8'h00);

    program_registers(8'h05, 8'h00, 8'h00, {3'b000, vpma_pkg::ROP_OR, 3'd7}, 8'h00,
                      {5'b00000, 1'b1, vpma_pkg::WMODE_3}, 8'hFF, 8'h0F);
    drive_item(vpma_pkg::OP_READ, 16'h8001, 8'h00);
    drive_item(vpma_pkg::OP_WRITE, 16'h8001, 8'h96);
    drive_item(vpma_pkg::OP_READ, 16'h8001, 8'h00);

    program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drive_item(vpma_pkg::OP_WRITE, 16'hFFFF, 8'h01);
    drive_item(vpma_pkg::OP_READ, 16'hFFFF, 8'h00);

    program_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    drive_item(vpma_pkg::OP_WRITE, 16'h0000, 8'hFF);
    drive_item(vpma_pkg::OP_READ, 16'h0000, 8'h00);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      random_settings();
      if (phase == 5) begin
        // The receiver stops for a long stretch while transactions keep coming.
        hold_off_go = 1'b1;
        run_phase(30, 1'b0);
        drain();
      end
      run_phase($urandom_range(20, 120), (phase % 4) != 3);
      if (phase == 9) begin
        drain();
        run_phase($urandom_range(20, 60), 1'b1);
      end
      phase++;
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("vga_planar_memory_access_top_tb: PASS");
    end else begin
      $display("vga_planar_memory_access_top_tb: FAIL");
    end
    $finish;
  end

endmodule
